// ----- src/dda_pkg.sv -----
// Shared types, constants and the control program of the DDA line rasterizer.
package dda_pkg;

	// Default configuration and parameter values.
	localparam int DDA_MAX_STEPS  = 64;
	localparam int DDA_FRAC_BITS  = 8;
	localparam logic [7:0] DDA_CELL_RESET = 8'd8;

	// Quotient bits of one increment: its magnitude stays below 2.0 in Q16.16.
	localparam int DDA_QBITS     = 17;
	localparam int DDA_DIV_CNT_W = $clog2(DDA_QBITS);

	// Program counter and program addresses.
	localparam int DDA_PC_W = 4;
	localparam logic [DDA_PC_W-1:0] PC_IDLE  = 4'd0;
	localparam logic [DDA_PC_W-1:0] PC_MUL0  = 4'd1;
	localparam logic [DDA_PC_W-1:0] PC_MUL1  = 4'd2;
	localparam logic [DDA_PC_W-1:0] PC_MUL2  = 4'd3;
	localparam logic [DDA_PC_W-1:0] PC_MUL3  = 4'd4;
	localparam logic [DDA_PC_W-1:0] PC_SPAN  = 4'd5;
	localparam logic [DDA_PC_W-1:0] PC_STEPS = 4'd6;
	localparam logic [DDA_PC_W-1:0] PC_INIT  = 4'd7;
	localparam logic [DDA_PC_W-1:0] PC_DIV   = 4'd8;
	localparam logic [DDA_PC_W-1:0] PC_EMIT  = 4'd9;

	// One line segment in map cells.
	typedef struct packed {
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] end_x;
		logic [15:0] end_y;
	} dda_in_t;

	// One plotted pixel.
	typedef struct packed {
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic        last;
		logic        truncated;
	} dda_out_t;

	// Operand picked for the shared scaling multiplier.
	typedef enum logic [1:0] {
		MUL_SX,
		MUL_SY,
		MUL_EX,
		MUL_EY
	} dda_mul_sel_t;

	// Sequencer branch condition of a control word.
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_WAIT_IN,
		COND_ZERO,
		COND_DIV,
		COND_EMIT
	} dda_cond_t;

	// One control word of the program.
	typedef struct packed {
		logic                acc_in;
		logic                mul_en;
		dda_mul_sel_t        mul_sel;
		logic                span_en;
		logic                steps_en;
		logic                init_en;
		logic                div_en;
		logic                emit_en;
		dda_cond_t           cond;
		logic [DDA_PC_W-1:0] target;
	} dda_ctl_t;

	// Control store: one word per program address.
	function automatic dda_ctl_t dda_ucode(input logic [DDA_PC_W-1:0] pc);
		dda_ctl_t w;
		w = '{acc_in: 1'b0, mul_en: 1'b0, mul_sel: MUL_SX, span_en: 1'b0,
			steps_en: 1'b0, init_en: 1'b0, div_en: 1'b0, emit_en: 1'b0,
			cond: COND_NEXT, target: PC_IDLE};
		unique case (pc)
			PC_IDLE: begin
				w.acc_in = 1'b1;
				w.cond   = COND_WAIT_IN;
			end
			PC_MUL0: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_SX;
			end
			PC_MUL1: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_SY;
			end
			PC_MUL2: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_EX;
			end
			PC_MUL3: begin
				w.mul_en  = 1'b1;
				w.mul_sel = MUL_EY;
			end
			PC_SPAN: begin
				w.span_en = 1'b1;
			end
			PC_STEPS: begin
				w.steps_en = 1'b1;
			end
			PC_INIT: begin
				w.init_en = 1'b1;
				w.cond    = COND_ZERO;
				w.target  = PC_IDLE;
			end
			PC_DIV: begin
				w.div_en = 1'b1;
				w.cond   = COND_DIV;
			end
			PC_EMIT: begin
				w.emit_en = 1'b1;
				w.cond    = COND_EMIT;
				w.target  = PC_IDLE;
			end
			default: begin
				w.cond   = COND_JUMP;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- src/dda_line_rasterizer.sv -----
// DDA line rasterizer: microcoded sequencer, shared multiplier and divider, pixel output.

// Takes one line segment (start and end in map cells, unsigned with FRAC_BITS
// fraction bits), scales it by cell_pixels and emits one pixel per DDA step,
// rounded half up, from the start point up to but not including the end point.
// A line whose step count exceeds MAX_STEPS stops after MAX_STEPS pixels, the
// last carrying last = 1 and all carrying truncated = 1; a zero-step line gives
// nothing. Work runs one line at a time: setup (four scaling multiplies through
// one 16x8 multiplier, span, step count, divider load), a restoring divide that
// produces both increments side by side, then one pixel per cycle while
// out_ready is high. in_ready is high only between lines; the output register
// lets the last pixel wait while the next line is taken. The user must write
// cell_pixels through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block itself does not enforce it.
module dda_line_rasterizer
	import dda_pkg::*;
#(
	parameter int MAX_STEPS = DDA_MAX_STEPS,
	parameter int FRAC_BITS = DDA_FRAC_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic     in_valid,
	output logic     in_ready,
	input  dda_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output dda_out_t out_data
);

	localparam int SHIFT  = 16 - FRAC_BITS;
	localparam int POS_W  = 24 + SHIFT;
	localparam int ACC_W  = (POS_W >= 32) ? POS_W + 1 : 33;
	localparam int STEP_W = 24 - FRAC_BITS;
	localparam int CNT_W  = $clog2(MAX_STEPS + 1);
	localparam int INC_W  = DDA_QBITS + 1;

	// Registers.
	logic [7:0]               cell_q;
	logic [DDA_PC_W-1:0]      pc_q, pc_next;
	dda_in_t                  in_q;
	logic [23:0]              sx_q, sy_q, ex_q, ey_q;
	logic [23:0]              adx_q, ady_q;
	logic                     neg_x_q, neg_y_q;
	logic [STEP_W-1:0]        steps_q;
	logic [STEP_W-1:0]        rem_x_q, rem_y_q;
	logic [DDA_QBITS-1:0]     dv_x_q, dv_y_q;
	logic [DDA_DIV_CNT_W-1:0] div_cnt_q;
	logic [CNT_W-1:0]         rem_cnt_q;
	logic                     cut_q;
	logic [ACC_W-1:0]         px_q, py_q;
	logic                     out_valid_q;
	dda_out_t                 out_q;

	// Combinational datapath signals.
	dda_ctl_t          ctl;
	logic [15:0]       mul_op;
	logic [23:0]       mul_prod;
	logic [STEP_W-1:0] tx, ty;
	logic [POS_W-1:0]  dividend_x, dividend_y;
	logic [STEP_W:0]   trial_x, trial_y;
	logic              ge_x, ge_y;
	logic [INC_W-1:0]  inc_x, inc_y;
	logic [ACC_W-1:0]  rnd_x, rnd_y;
	logic              slot_free, emit_fire;

	assign ctl       = dda_ucode(pc_q);
	assign in_ready  = ctl.acc_in;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign emit_fire = ctl.emit_en && slot_free;

	// Cell size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= DDA_CELL_RESET;
		end else if (cfg_wr_en) begin
			cell_q <= cfg_wr_data;
		end
	end

	// Sequencer program counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	// Branch decode of the current control word.
	always_comb begin
		pc_next = pc_q + DDA_PC_W'(1);
		unique case (ctl.cond)
			COND_NEXT:    pc_next = pc_q + DDA_PC_W'(1);
			COND_JUMP:    pc_next = ctl.target;
			COND_WAIT_IN: pc_next = in_valid ? pc_q + DDA_PC_W'(1) : pc_q;
			COND_ZERO:    pc_next = (steps_q == '0) ? ctl.target : pc_q + DDA_PC_W'(1);
			COND_DIV:     pc_next = (div_cnt_q == '0) ? pc_q + DDA_PC_W'(1) : pc_q;
			COND_EMIT:    pc_next = (emit_fire && rem_cnt_q == CNT_W'(1)) ? ctl.target : pc_q;
			default:      pc_next = PC_IDLE;
		endcase
	end

	// Shared scaling multiplier: one coordinate times the cell size per step.
	always_comb begin
		case (ctl.mul_sel)
			MUL_SX:  mul_op = in_q.start_x;
			MUL_SY:  mul_op = in_q.start_y;
			MUL_EX:  mul_op = in_q.end_x;
			MUL_EY:  mul_op = in_q.end_y;
			default: mul_op = in_q.start_x;
		endcase
		mul_prod = {8'd0, mul_op} * {16'd0, cell_q};
	end

	// Truncated spans, divider operands and one restoring divide step per axis.
	assign tx         = adx_q[23:FRAC_BITS];
	assign ty         = ady_q[23:FRAC_BITS];
	assign dividend_x = POS_W'(adx_q) << SHIFT;
	assign dividend_y = POS_W'(ady_q) << SHIFT;
	assign trial_x    = {rem_x_q, dv_x_q[DDA_QBITS-1]};
	assign trial_y    = {rem_y_q, dv_y_q[DDA_QBITS-1]};
	assign ge_x       = trial_x >= {1'b0, steps_q};
	assign ge_y       = trial_y >= {1'b0, steps_q};

	// Signed increments and rounded pixel positions.
	assign inc_x = neg_x_q ? -{1'b0, dv_x_q} : {1'b0, dv_x_q};
	assign inc_y = neg_y_q ? -{1'b0, dv_y_q} : {1'b0, dv_y_q};
	assign rnd_x = px_q + ACC_W'(32768);
	assign rnd_y = py_q + ACC_W'(32768);

	// Datapath registers, each loaded by its control word field.
	always_ff @(posedge clk) begin
		if (ctl.acc_in && in_valid) begin
			in_q <= in_data;
		end
		if (ctl.mul_en) begin
			case (ctl.mul_sel)
				MUL_SX:  sx_q <= mul_prod;
				MUL_SY:  sy_q <= mul_prod;
				MUL_EX:  ex_q <= mul_prod;
				MUL_EY:  ey_q <= mul_prod;
				default: sx_q <= mul_prod;
			endcase
		end
		if (ctl.span_en) begin
			neg_x_q <= ex_q < sx_q;
			neg_y_q <= ey_q < sy_q;
			adx_q   <= (ex_q >= sx_q) ? ex_q - sx_q : sx_q - ex_q;
			ady_q   <= (ey_q >= sy_q) ? ey_q - sy_q : sy_q - ey_q;
		end
		if (ctl.steps_en) begin
			steps_q <= (tx > ty) ? tx : ty;
		end
		if (ctl.init_en) begin
			// The quotient fits 17 bits, so the dividend's upper part is below the divisor.
			rem_x_q <= STEP_W'(dividend_x >> DDA_QBITS);
			rem_y_q <= STEP_W'(dividend_y >> DDA_QBITS);
			dv_x_q  <= dividend_x[DDA_QBITS-1:0];
			dv_y_q  <= dividend_y[DDA_QBITS-1:0];
			px_q    <= ACC_W'(sx_q) << SHIFT;
			py_q    <= ACC_W'(sy_q) << SHIFT;
			cut_q   <= steps_q > STEP_W'(MAX_STEPS);
		end
		if (ctl.div_en) begin
			rem_x_q <= ge_x ? STEP_W'(trial_x - {1'b0, steps_q}) : STEP_W'(trial_x);
			rem_y_q <= ge_y ? STEP_W'(trial_y - {1'b0, steps_q}) : STEP_W'(trial_y);
			dv_x_q  <= {dv_x_q[DDA_QBITS-2:0], ge_x};
			dv_y_q  <= {dv_y_q[DDA_QBITS-2:0], ge_y};
		end
		if (emit_fire) begin
			out_q.pixel_x   <= rnd_x[31:16];
			out_q.pixel_y   <= rnd_y[31:16];
			out_q.last      <= rem_cnt_q == CNT_W'(1);
			out_q.truncated <= cut_q;
			px_q            <= px_q + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
			py_q            <= py_q + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
		end
	end

	// Loop counters of the divide and the pixel emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			rem_cnt_q <= '0;
		end else begin
			if (ctl.init_en) begin
				div_cnt_q <= DDA_DIV_CNT_W'(DDA_QBITS - 1);
				rem_cnt_q <= (steps_q > STEP_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS)
					: CNT_W'(steps_q);
			end else if (ctl.div_en && div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - DDA_DIV_CNT_W'(1);
			end
			if (emit_fire) begin
				rem_cnt_q <= rem_cnt_q - CNT_W'(1);
			end
		end
	end

	// Output register: filled by an emission, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The divisor is never zero while dividing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_DIV) |-> (steps_q != '0))
		else $error("divide entered with zero step count");

	// The partial remainders stay below the divisor during the divide.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_DIV) |-> (rem_x_q < steps_q && rem_y_q < steps_q))
		else $error("divide remainder out of range");

	// The emission loop always has a pixel left to send.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == PC_EMIT) |-> (rem_cnt_q != '0))
		else $error("emission loop with no pixels left");

	// A transfer marked last leaves the sequencer outside the emission loop.
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && rem_cnt_q == CNT_W'(1)) |=> (pc_q == PC_IDLE && out_data.last))
		else $error("last pixel not followed by return to idle");

endmodule

// ----- test/tb_top.sv -----
// Testbench for the DDA line rasterizer: random and directed segments, checked pixel by pixel.
module tb_top;
	import dda_pkg::*;

	localparam int FRAC        = DDA_FRAC_BITS;
	localparam int POS_SHIFT   = 16 - FRAC;
	localparam int MAX_PIX     = DDA_MAX_STEPS;
	localparam int SETTLE      = 40;
	localparam int STALL_LIMIT = 4000;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = '0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	dda_in_t    in_data     = '0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	dda_out_t   out_data;

	// Scale factor the block currently holds, mirrored here.
	logic [7:0] cell_px = DDA_CELL_RESET;

	dda_in_t  seg_q[$];
	dda_out_t pixel_q[$];
	dda_out_t want;
	int       mismatches  = 0;
	int       idle_cycles = 0;
	int       gap_left    = 0;
	int       stall_left  = 0;
	bit       calm        = 1'b0;

	dda_line_rasterizer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Rounds a Q16.16 position half up to a whole pixel.
	function automatic logic [15:0] round_px(input longint p);
		if (p < 0)
			p = 0;
		return 16'((p + 64'sd32768) >>> 16);
	endfunction

	// Works out every pixel that one segment produces at the current scale.
	task automatic plot_line(input dda_in_t seg);
		logic [23:0] sx, sy, ex, ey, span_x, span_y;
		logic [15:0] steps_x, steps_y, steps;
		longint      pos_x, pos_y, inc_x, inc_y;
		int          count;
		dda_out_t    pix;
		sx = seg.start_x * cell_px;
		sy = seg.start_y * cell_px;
		ex = seg.end_x * cell_px;
		ey = seg.end_y * cell_px;
		span_x = (ex >= sx) ? ex - sx : sx - ex;
		span_y = (ey >= sy) ? ey - sy : sy - ey;
		steps_x = 16'(span_x >> FRAC);
		steps_y = 16'(span_y >> FRAC);
		steps = (steps_x > steps_y) ? steps_x : steps_y;
		if (steps == 0)
			return;
		pos_x = longint'(sx) << POS_SHIFT;
		pos_y = longint'(sy) << POS_SHIFT;
		inc_x = ((longint'(ex) << POS_SHIFT) - pos_x) / longint'(steps);
		inc_y = ((longint'(ey) << POS_SHIFT) - pos_y) / longint'(steps);
		count = (steps > MAX_PIX) ? MAX_PIX : int'(steps);
		for (int k = 0; k < count; k++) begin
			pix.pixel_x   = round_px(pos_x);
			pix.pixel_y   = round_px(pos_y);
			pix.last      = (k + 1 == count);
			pix.truncated = (steps > MAX_PIX);
			pixel_q.push_back(pix);
			pos_x += inc_x;
			pos_y += inc_y;
		end
	endtask

	// Idle length: mostly none, sometimes a few cycles, rarely a long pause.
	function automatic int pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 100);
	endfunction

	// Moves a coordinate by d in a random direction, staying in range.
	function automatic logic [15:0] nudge(input logic [15:0] c, input int unsigned d);
		if ($urandom_range(0, 1) == 1 && c + d <= 65535)
			return 16'(c + d);
		if (c >= d)
			return 16'(c - d);
		return 16'(c + d);
	endfunction

	// Mostly segments sized to stay near the step limit at the current scale.
	function automatic dda_in_t rand_seg();
		dda_in_t     s;
		int unsigned kind, reach;
		kind = $urandom_range(0, 99);
		s.start_x = 16'($urandom);
		s.start_y = 16'($urandom);
		if (kind < 12) begin
			s.end_x = 16'($urandom);
			s.end_y = 16'($urandom);
		end else if (kind < 20) begin
			// Spans below one pixel, so no step at all.
			reach = 255 / cell_px;
			s.end_x = nudge(s.start_x, $urandom_range(0, reach));
			s.end_y = nudge(s.start_y, $urandom_range(0, reach));
		end else begin
			reach = ($urandom_range(1, 72) * 256) / cell_px + 1;
			s.end_x = nudge(s.start_x,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, reach));
			s.end_y = nudge(s.start_y,
				($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, reach));
		end
		return s;
	endfunction

	// Input driver: presents queued segments with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready)
				plot_line(in_data);
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (seg_q.size() > 0) begin
					in_data  <= seg_q.pop_front();
					in_valid <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each pixel transfer and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					$display("%0t: unexpected pixel x=%0d y=%0d last=%0b truncated=%0b",
						$time, out_data.pixel_x, out_data.pixel_y, out_data.last,
						out_data.truncated);
					mismatches++;
				end else begin
					want = pixel_q.pop_front();
					if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y
							|| out_data.last !== want.last
							|| out_data.truncated !== want.truncated) begin
						$display("%0t: expected x=%0d y=%0d last=%0b truncated=%0b, got x=%0d y=%0d last=%0b truncated=%0b",
							$time, want.pixel_x, want.pixel_y, want.last, want.truncated,
							out_data.pixel_x, out_data.pixel_y, out_data.last,
							out_data.truncated);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= pick_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic add_seg(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] ex, input logic [15:0] ey);
		seg_q.push_back('{start_x: sx, start_y: sy, end_x: ex, end_y: ey});
	endtask

	task automatic fill_random(input int count);
		@(negedge clk);
		repeat (count)
			seg_q.push_back(rand_seg());
	endtask

	// Waits until every segment is taken and every pixel has come back.
	task automatic drain();
		while (seg_q.size() != 0 || in_valid || pixel_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cell(input logic [7:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cell_px = v;
		@(negedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset scale of 8 pixels per cell: one step per 0x20 of span.
		add_seg(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		add_seg(16'h1234, 16'h1234, 16'h1234, 16'h1234);
		add_seg(16'h0000, 16'h0000, 16'h001F, 16'h001F);
		add_seg(16'h0000, 16'h0000, 16'h0020, 16'h0000);
		add_seg(16'h0000, 16'h0000, 16'h0000, 16'h0100);
		add_seg(16'h0100, 16'h0100, 16'h0000, 16'h0000);
		add_seg(16'h0010, 16'h0010, 16'h0210, 16'h0090);
		add_seg(16'h000F, 16'h0F0F, 16'h030F, 16'h0A0F);
		add_seg(16'h0000, 16'h0000, 16'h0800, 16'h0000);
		add_seg(16'h0000, 16'h0000, 16'h0820, 16'h0010);
		add_seg(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
		add_seg(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
		add_seg(16'hFFFF, 16'hFFFF, 16'hFFE0, 16'hFFFF);
		add_seg(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0800);
		add_seg(16'h0123, 16'h0456, 16'h0789, 16'h0ABC);
		drain();

		// Largest scale: positions reach the top of the pixel range.
		write_cell(8'd255);
		add_seg(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
		add_seg(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
		add_seg(16'hFFFF, 16'hFFFF, 16'hFFFD, 16'hFFFF);
		add_seg(16'h0101, 16'h0000, 16'h0000, 16'h0001);
		fill_random(80);
		drain();

		// Smallest scale.
		write_cell(8'd1);
		add_seg(16'h0000, 16'h0000, 16'h0100, 16'h0000);
		add_seg(16'h0000, 16'h0000, 16'hFFFF, 16'h0FFF);
		add_seg(16'h1000, 16'h2000, 16'h1040, 16'h1FC0);
		fill_random(80);
		drain();

		// A stretch with no idling on either side.
		write_cell(8'd3);
		calm = 1'b1;
		fill_random(60);
		drain();
		calm = 1'b0;

		write_cell(8'($urandom_range(2, 254)));
		fill_random(95);
		drain();

		write_cell(8'd8);
		fill_random(95);
		drain();

		if (mismatches == 0 && pixel_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- dda_line_rasterizer.f -----
src/dda_pkg.sv
src/dda_line_rasterizer.sv
test/tb_top.sv
